// ===== rtl/lpht_pkg.sv =====
// Shared types and constants for the linear probing hash table.
// No dependencies; every other file imports this package.
package lpht_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int KEY_WIDTH_DEF = 16;

    localparam int CMD_BITS    = 2;
    localparam int KEY_BITS    = 16;
    localparam int STATUS_BITS = 2;
    localparam int SLOT_BITS   = 4;

    localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_SEARCH = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd2;

    localparam int TAG_BITS = 2;
    localparam logic [TAG_BITS-1:0] TAG_EMPTY = 2'd0;
    localparam logic [TAG_BITS-1:0] TAG_USED  = 2'd1;
    localparam logic [TAG_BITS-1:0] TAG_GONE  = 2'd2;

endpackage

// ===== rtl/linear_probe_hash_table_core.sv =====
// Linear probing hash set with tombstones, state held in one slot memory.
// Depends on lpht_pkg and lpht_home.
//
// Usage:
//   Input channel (in_valid/in_ready, cmd, key) takes one command item:
//   insert, remove or search. Output channel (out_valid/out_ready, status,
//   slot_index) returns exactly one result item per command, in order.
//   An item passes from acceptance to result through the home slot
//   remainder, the first slot memory read, the probe of 1 to NUM_SLOTS
//   slots (reads stream back to back from a registered read port) and the
//   load of the output register; an unused command goes straight to the
//   output register. One item is worked on at a time: the next item is
//   accepted only once the last one is in the output register.
//   After reset a clearing pass marks every slot empty, one slot per cycle;
//   in_ready stays low until it ends.
//   The result sits in an output register: a new item is accepted while
//   it waits. If the receiver stalls, the next finished result holds in
//   the core until the output register frees, and in_ready stays low.
module linear_probe_hash_table_core #(
    parameter int NUM_SLOTS = lpht_pkg::NUM_SLOTS_DEF,
    parameter int KEY_WIDTH = lpht_pkg::KEY_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [lpht_pkg::CMD_BITS-1:0]    cmd,
    input  logic [lpht_pkg::KEY_BITS-1:0]    key,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [lpht_pkg::STATUS_BITS-1:0] status,
    output logic [lpht_pkg::SLOT_BITS-1:0]   slot_index
);
    import lpht_pkg::*;

    localparam int IW = $clog2(NUM_SLOTS);
    localparam int CW = IW + 1;
    localparam int WW = TAG_BITS + KEY_WIDTH;
    localparam logic [IW-1:0] LastSlot  = IW'(NUM_SLOTS - 1);
    localparam logic [CW-1:0] SlotCount = CW'(NUM_SLOTS);
    localparam logic [CW-1:0] LastCount = CW'(NUM_SLOTS - 1);
    localparam logic [KEY_BITS-1:0] KeyMask =
        (KEY_WIDTH >= KEY_BITS) ? {KEY_BITS{1'b1}}
                                : KEY_BITS'((32'd1 << KEY_WIDTH) - 32'd1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_FINISH
    } state_t;

    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] idx);
        next_slot = (idx == LastSlot) ? '0 : idx + IW'(1);
    endfunction

    state_t               state_reg, state_next;
    logic [IW-1:0]        clr_idx_reg, clr_idx_next;
    logic [CMD_BITS-1:0]  cmd_reg, cmd_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [IW-1:0]        issue_idx_reg, issue_idx_next;
    logic [CW-1:0]        issue_cnt_reg, issue_cnt_next;
    logic [IW-1:0]        eval_idx_reg;
    logic                 eval_vld_reg, eval_vld_next;
    logic [CW-1:0]        eval_cnt_reg, eval_cnt_next;
    logic [STATUS_BITS-1:0] res_status_reg, res_status_next;
    logic [SLOT_BITS-1:0] res_slot_reg, res_slot_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_BITS-1:0] status_reg, status_next;
    logic [SLOT_BITS-1:0] slot_reg, slot_next;

    logic [WW-1:0]        mem [NUM_SLOTS];
    logic [WW-1:0]        mem_q_reg;
    logic                 mem_we;
    logic [IW-1:0]        mem_wa;
    logic [WW-1:0]        mem_wd;
    logic                 rd_en;

    logic [KEY_BITS-1:0]  key_masked;
    logic                 home_start;
    logic                 home_done;
    logic [IW-1:0]        home;

    logic [TAG_BITS-1:0]  q_tag;
    logic [KEY_WIDTH-1:0] q_key;
    logic                 is_insert;
    logic                 hit;
    logic                 stop_miss;
    logic                 done_now;

    assign key_masked = key & KeyMask;
    assign in_ready   = (state_reg == S_IDLE);
    assign home_start = in_valid && in_ready && (cmd != CMD_UNUSED);

    lpht_home #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_home (
        .clk   (clk),
        .rst_n (rst_n),
        .start (home_start),
        .key   (key_masked),
        .done  (home_done),
        .home  (home)
    );

    assign q_tag     = mem_q_reg[WW-1 -: TAG_BITS];
    assign q_key     = mem_q_reg[KEY_WIDTH-1:0];
    assign is_insert = (cmd_reg == CMD_INSERT);

    // Insert takes any slot not in use; remove and search need a live match.
    always_comb
    begin
        if (is_insert)
        begin
            hit       = (q_tag != TAG_USED);
            stop_miss = 1'b0;
        end
        else
        begin
            hit       = (q_tag == TAG_USED) && (q_key == key_reg);
            stop_miss = (q_tag == TAG_EMPTY);
        end
        done_now = eval_vld_reg && (hit || stop_miss || (eval_cnt_reg == LastCount));
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        issue_idx_next  = issue_idx_reg;
        issue_cnt_next  = issue_cnt_reg;
        eval_cnt_next   = eval_cnt_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        mem_we          = 1'b0;
        mem_wa          = eval_idx_reg;
        mem_wd          = {TAG_USED, key_reg};
        rd_en           = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_wa       = clr_idx_reg;
                mem_wd       = {TAG_EMPTY, {KEY_WIDTH{1'b0}}};
                clr_idx_next = clr_idx_reg + IW'(1);
                if (clr_idx_reg == LastSlot)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = cmd;
                    key_next = KEY_WIDTH'(key_masked);
                    if (cmd == CMD_UNUSED)
                    begin
                        res_status_next = ST_MISS;
                        res_slot_next   = '0;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (home_done)
                begin
                    issue_idx_next = home;
                    issue_cnt_next = '0;
                    eval_cnt_next  = '0;
                    state_next     = S_PROBE;
                end
            end
            S_PROBE:
            begin
                // Stream reads one slot ahead; drop the one in flight at the end.
                rd_en = !done_now && (issue_cnt_reg < SlotCount);
                if (rd_en)
                begin
                    issue_idx_next = next_slot(issue_idx_reg);
                    issue_cnt_next = issue_cnt_reg + CW'(1);
                end
                if (eval_vld_reg)
                begin
                    eval_cnt_next = eval_cnt_reg + CW'(1);
                end
                if (done_now)
                begin
                    state_next = S_FINISH;
                    if (hit)
                    begin
                        res_status_next = ST_OK;
                        res_slot_next   = SLOT_BITS'(eval_idx_reg);
                        if (is_insert)
                        begin
                            mem_we = 1'b1;
                            mem_wd = {TAG_USED, key_reg};
                        end
                        else if (cmd_reg == CMD_REMOVE)
                        begin
                            mem_we = 1'b1;
                            mem_wd = {TAG_GONE, q_key};
                        end
                    end
                    else
                    begin
                        res_status_next = is_insert ? ST_FULL : ST_MISS;
                        res_slot_next   = '0;
                    end
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    slot_next      = res_slot_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        eval_vld_next = rd_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            issue_cnt_reg <= '0;
            eval_vld_reg  <= 1'b0;
            eval_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            slot_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            issue_cnt_reg <= issue_cnt_next;
            eval_vld_reg  <= eval_vld_next;
            eval_cnt_reg  <= eval_cnt_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            slot_reg      <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        issue_idx_reg  <= issue_idx_next;
        eval_idx_reg   <= issue_idx_reg;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
    end

    // Slot memory: tag and key per slot, one write and one registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        mem_q_reg <= mem[issue_idx_reg];
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot_index = slot_reg;

endmodule

// ===== rtl/lpht_home.sv =====
// Home slot unit: key mod NUM_SLOTS by reciprocal multiplication.
// Depends on lpht_pkg.
module lpht_home #(
    parameter int NUM_SLOTS = lpht_pkg::NUM_SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lpht_pkg::KEY_BITS-1:0] key,
    output logic                          done,
    output logic [$clog2(NUM_SLOTS)-1:0]  home
);
    import lpht_pkg::*;

    localparam int IW         = $clog2(NUM_SLOTS);
    localparam int RW         = KEY_BITS + 1;
    localparam int PW         = KEY_BITS + RW;
    localparam int RecipShift = KEY_BITS + IW;
    localparam int QW         = PW - RecipShift;
    localparam logic [63:0] RecipFull =
        ((64'd1 << RecipShift) + 64'(NUM_SLOTS) - 64'd1) / 64'(NUM_SLOTS);
    localparam logic [RW-1:0] Recip    = RW'(RecipFull);
    localparam logic [IW-1:0] SlotsLow = IW'(NUM_SLOTS);

    logic                prod_vld_reg;
    logic                done_reg;
    logic [PW-1:0]       prod_reg;
    logic [IW-1:0]       klow_reg;
    logic [IW-1:0]       rem_reg;
    logic [QW-1:0]       quot;
    logic [QW+IW-1:0]    qd_full;

    // The quotient is exact for every 16-bit key; only the low bits of
    // quotient times slot count are needed for the remainder.
    always_comb
    begin
        quot    = prod_reg[PW-1:RecipShift];
        qd_full = (QW+IW)'(quot) * (QW+IW)'(SlotsLow);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= start;
            done_reg     <= prod_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= PW'(key) * PW'(Recip);
            klow_reg <= key[IW-1:0];
        end
        if (prod_vld_reg)
        begin
            rem_reg <= klow_reg - qd_full[IW-1:0];
        end
    end

    assign done = done_reg;
    assign home = rem_reg;

endmodule

// ===== dv/tb_linear_probe_hash_table_core.sv =====
// Self-checking testbench for linear_probe_hash_table_core: directed probe and
// full-table items, random command traffic with idling, then back to back.
// Depends on lpht_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_linear_probe_hash_table_core;
    import lpht_pkg::*;

    localparam int SLOTS = NUM_SLOTS_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [SLOT_BITS-1:0]   slot;
    } answer_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [CMD_BITS-1:0]    cmd = CMD_INSERT;
    logic [KEY_BITS-1:0]    key = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [STATUS_BITS-1:0] status;
    logic [SLOT_BITS-1:0]   slot_index;

    // Predictor state: one tag and one key per bucket
    logic [TAG_BITS-1:0] bucket_tag [SLOTS];
    logic [KEY_BITS-1:0] bucket_key [SLOTS];
    answer_t             awaited_answers [$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  stall_left = 0;
    bit  quiet_mode = 1'b0;

    linear_probe_hash_table_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .key        (key),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .slot_index (slot_index)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver side: stall in random bursts unless in the steady stretch
    always @(posedge clk)
    begin
        if (quiet_mode)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 14) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    function automatic answer_t predict_table_answer(logic [CMD_BITS-1:0] c,
                                                     logic [KEY_BITS-1:0] k);
        answer_t ans;
        int      home;
        int      idx;
        ans.status = ST_MISS;
        ans.slot   = '0;
        home = int'(k) % SLOTS;
        if (c == CMD_INSERT)
        begin
            ans.status = ST_FULL;
            for (int i = 0; i < SLOTS; i++)
            begin
                idx = (home + i) % SLOTS;
                if (bucket_tag[idx] != TAG_USED)
                begin
                    bucket_tag[idx] = TAG_USED;
                    bucket_key[idx] = k;
                    ans.status = ST_OK;
                    ans.slot   = SLOT_BITS'(idx);
                    break;
                end
            end
        end
        else if (c == CMD_REMOVE || c == CMD_SEARCH)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                idx = (home + i) % SLOTS;
                if (bucket_tag[idx] == TAG_USED && bucket_key[idx] == k)
                begin
                    if (c == CMD_REMOVE)
                        bucket_tag[idx] = TAG_GONE;
                    ans.status = ST_OK;
                    ans.slot   = SLOT_BITS'(idx);
                    break;
                end
                // an empty bucket ends the probe; deleted ones are passed over
                if (bucket_tag[idx] == TAG_EMPTY)
                    break;
            end
        end
        return ans;
    endfunction

    // Drive one item, wait for its handshake, then record the expected answer
    task automatic send_command(input logic [CMD_BITS-1:0] c, input logic [KEY_BITS-1:0] k);
        if (!quiet_mode && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        key      <= k;
        do
            @(posedge clk);
        while (!in_ready);
        awaited_answers.push_back(predict_table_answer(c, k));
    endtask

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_answers.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result expected none actual status=%0d slot_index=%0d",
                         $time, status, slot_index);
            end
            else
            begin
                want = awaited_answers.pop_front();
                if (status !== want.status)
                begin
                    mismatch_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, status);
                end
                if (slot_index !== want.slot)
                begin
                    mismatch_count++;
                    $display("%0t: slot_index expected %0d actual %0d",
                             $time, want.slot, slot_index);
                end
            end
        end
    end

    // Collisions at the top of the table, wrap to slot 0, tombstones, duplicates
    task automatic test_probe_wraparound();
        send_command(CMD_SEARCH, 16'h0000);
        send_command(CMD_INSERT, 16'hFFFF);
        send_command(CMD_INSERT, 16'h000F);
        send_command(CMD_INSERT, 16'h000F);
        send_command(CMD_REMOVE, 16'hFFFF);
        send_command(CMD_REMOVE, 16'h000F);
        send_command(CMD_SEARCH, 16'h000F);
        send_command(CMD_UNUSED, 16'hFFFF);
    endtask

    // Fill every free bucket from home 0, then overflow and miss after a full lap
    task automatic test_full_table();
        for (int i = 0; i < 14; i++)
            send_command(CMD_INSERT, KEY_BITS'(i * 16));
        send_command(CMD_INSERT, 16'hFFF0);
        send_command(CMD_INSERT, 16'hFFFF);
        send_command(CMD_SEARCH, 16'h0008);
        send_command(CMD_SEARCH, 16'hFFF0);
    endtask

    // Fill-heavy, balanced or drain-heavy epochs; keys mostly stored or colliding
    task automatic random_traffic(input int count);
        int                  insert_pct;
        int                  pick;
        logic [CMD_BITS-1:0] c;
        logic [KEY_BITS-1:0] k;
        logic [KEY_BITS-1:0] stored [$];
        insert_pct = 50;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                pick = $urandom_range(0, 2);
                insert_pct = (pick == 0) ? 20 : (pick == 1) ? 50 : 85;
            end
            pick = $urandom_range(0, 99);
            if (pick < 2)
                c = CMD_UNUSED;
            else if ($urandom_range(0, 99) < insert_pct)
                c = CMD_INSERT;
            else if ($urandom_range(0, 99) < 55)
                c = CMD_REMOVE;
            else
                c = CMD_SEARCH;

            stored.delete();
            for (int i = 0; i < SLOTS; i++)
                if (bucket_tag[i] == TAG_USED)
                    stored.push_back(bucket_key[i]);

            pick = $urandom_range(0, 99);
            if (pick < 55 && stored.size() != 0)
                k = stored[$urandom_range(0, stored.size() - 1)];
            else if (pick < 85)
            begin
                // homes 14, 15, 0, 1 so chains cross the wrap point
                k[3:0]  = 4'(14 + $urandom_range(0, 3));
                k[15:4] = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 3))
                                                      : 12'($urandom);
            end
            else
                k = KEY_BITS'($urandom);
            send_command(c, k);
        end
    endtask

    task automatic test_random_traffic();
        random_traffic(900);
    endtask

    task automatic test_back_to_back();
        quiet_mode = 1'b1;
        random_traffic(125);
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            bucket_tag[i] = TAG_EMPTY;
            bucket_key[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_probe_wraparound();
        test_full_table();
        test_random_traffic();
        test_back_to_back();

        in_valid <= 1'b0;
        while (awaited_answers.size() != 0)
            @(posedge clk);
        // catch any stray result after the last one
        repeat (60) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
